### design/pd_actuator_delay_slew_chain_top_macros.svh
// Assertion macros used by the top design file.
`ifndef PD_ACTUATOR_DELAY_SLEW_CHAIN_TOP_MACROS_SVH
`define PD_ACTUATOR_DELAY_SLEW_CHAIN_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define PDC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Implication checked on every rising clock edge, including reset.
`define PDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

### design/pdc_pkg.sv
// -----------------------------------------------------------------------------
// pdc_pkg
// Shared types and constants of the PD actuator delay and slew chain.
// -----------------------------------------------------------------------------
package pdc_pkg;
   localparam int RING_DEPTH_DEFAULT = 64;
   localparam logic [15:0] PROP_GAIN_RST  = 16'd5243;
   localparam logic [15:0] DERIV_GAIN_RST = 16'd5243;
   localparam logic [13:0] TILT_LIMIT_RST = 14'd1280;
   localparam logic [11:0] SCALE_X_RST    = 12'd2081;
   localparam logic [11:0] SCALE_Y_RST    = 12'd1108;
   localparam logic [15:0] RATE_ALPHA_RST = 16'd58982;

   localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
   localparam logic [2:0] REG_DERIV_GAIN = 3'd1;
   localparam logic [2:0] REG_TILT_LIMIT = 3'd2;
   localparam logic [2:0] REG_SCALE_X    = 3'd3;
   localparam logic [2:0] REG_SCALE_Y    = 3'd4;
   localparam logic [2:0] REG_DELAY_MS   = 3'd5;
   localparam logic [2:0] REG_SLEW_DPS   = 3'd6;
   localparam logic [2:0] REG_RATE_ALPHA = 3'd7;

   // Reciprocal of 1000 in Q0.40, rounded up: floor(x*M >> 40) = floor(x/1000)
   // for x below 2^31.
   localparam logic [31:0] RECIP_1000 = 32'd1099511628;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_AVG_A, ST_AVG_B, ST_PD_A, ST_PD_B, ST_SCALE,
      ST_AXIS_NEXT,
      ST_RING_WR, ST_RING_RD, ST_RING_CHK,
      ST_STEP, ST_DIV, ST_SLEW,
      ST_DONE
   } state_type;
endpackage

### design/pd_actuator_delay_slew_chain_top.sv
// -----------------------------------------------------------------------------
// pd_actuator_delay_slew_chain_top
// Two-axis PD thrust-vector chain with delay ring and slew limiter.
// -----------------------------------------------------------------------------
// Channel   Direction  Handshake         Payload
// req_      in         tvalid/tready     tuser restart, tdata tick fields
// rsp_      out        tvalid/tready     tdata command fields
// csr_      in         APB write/read    eight control registers
//
// Both axes go through one shared 33x33 signed multiplier, five products each.
// With a delay set, the ring then takes a write, a read and an age check, and a
// released command takes the step multiply, its reciprocal divide and the slew
// update. A held command skips these and goes straight to the final state.
// The next item can be taken in the same cycle that the result is issued.
// A new item may be taken while the previous result waits; its own result
// then waits in the final state until rsp_tready takes the older one.
// Reset clears averages, slew state and ring pointers and reloads the registers.
// The result is held stable until rsp_tready is high.
// -----------------------------------------------------------------------------
module pd_actuator_delay_slew_chain_top #(
   parameter int RING_DEPTH = pdc_pkg::RING_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: now_ms[31:0], tilt_x[48:32], tilt_y[65:49], raw_rate_x[85:66],
   // raw_rate_y[105:86], zero fill [111:106]
   input  logic [111:0] req_tdata,
   // tuser: restart
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: servo_x[18:0], servo_y[37:19], saturated[38], zero fill [39]
   output logic [39:0] rsp_tdata,
   // tuser: cmd_valid
   output logic        rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import pdc_pkg::*;
`include "pd_actuator_delay_slew_chain_top_macros.svh"

   localparam int PW = $clog2(RING_DEPTH);
   localparam int CW = $clog2(RING_DEPTH + 1);

   // Configuration registers.
   logic [15:0] prop_gain_ff, deriv_gain_ff, rate_alpha_ff;
   logic [13:0] tilt_limit_ff;
   logic [11:0] scale_x_ff, scale_y_ff, slew_dps_ff;
   logic [9:0]  delay_ms_ff;

   logic       wr_en;
   logic [2:0] reg_idx;
   assign csr_pready = 1'b1;
   assign wr_en   = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= PROP_GAIN_RST;
         deriv_gain_ff <= DERIV_GAIN_RST;
         tilt_limit_ff <= TILT_LIMIT_RST;
         scale_x_ff    <= SCALE_X_RST;
         scale_y_ff    <= SCALE_Y_RST;
         delay_ms_ff   <= '0;
         slew_dps_ff   <= '0;
         rate_alpha_ff <= RATE_ALPHA_RST;
      end else if (wr_en) begin
         case (reg_idx)
            REG_PROP_GAIN:  prop_gain_ff  <= csr_pwdata[15:0];
            REG_DERIV_GAIN: deriv_gain_ff <= csr_pwdata[15:0];
            REG_TILT_LIMIT: tilt_limit_ff <= csr_pwdata[13:0];
            REG_SCALE_X:    scale_x_ff    <= csr_pwdata[11:0];
            REG_SCALE_Y:    scale_y_ff    <= csr_pwdata[11:0];
            REG_DELAY_MS:   delay_ms_ff   <= csr_pwdata[9:0];
            REG_SLEW_DPS:   slew_dps_ff   <= csr_pwdata[11:0];
            REG_RATE_ALPHA: rate_alpha_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_PROP_GAIN:  csr_prdata = {16'd0, prop_gain_ff};
         REG_DERIV_GAIN: csr_prdata = {16'd0, deriv_gain_ff};
         REG_TILT_LIMIT: csr_prdata = {18'd0, tilt_limit_ff};
         REG_SCALE_X:    csr_prdata = {20'd0, scale_x_ff};
         REG_SCALE_Y:    csr_prdata = {20'd0, scale_y_ff};
         REG_DELAY_MS:   csr_prdata = {22'd0, delay_ms_ff};
         REG_SLEW_DPS:   csr_prdata = {20'd0, slew_dps_ff};
         REG_RATE_ALPHA: csr_prdata = {16'd0, rate_alpha_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // Item fields, latched on acceptance.
   logic [31:0] now_ff;
   logic signed [16:0] tilt_x_ff, tilt_y_ff;
   logic signed [19:0] raw_x_ff, raw_y_ff;

   // Persistent state.
   logic signed [19:0] avg_x_ff, avg_y_ff;
   logic signed [18:0] slew_x_ff, slew_y_ff;
   logic [31:0] last_time_ff;
   logic [PW-1:0] head_ff;
   logic [CW-1:0] count_ff;

   // Ring memory: x, y command and stamp in one word.
   logic [69:0] ring_mem [RING_DEPTH];
   logic [69:0] ring_rd_ff;

   // Working registers.
   state_type   state_ff, state_in;
   logic        axis_ff;
   logic signed [49:0] acc_ff;
   logic signed [63:0] prod_ff;
   logic signed [18:0] cmd_x_ff, cmd_y_ff;
   logic        sat_ff, valid_ff;
   logic [31:0] dt_ff;
   logic [29:0] step_ff;
   logic        out_valid_ff;
   logic [39:0] out_data_ff;
   logic        out_user_ff;

   // Shared multiplier with a registered product.
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   assign mul_p = mul_a * mul_b;

   logic signed [19:0] cur_avg, cur_raw;
   logic signed [16:0] cur_tilt;
   logic signed [19:0] lim_s;
   logic signed [49:0] rnd16;
   logic signed [33:0] pd_val;
   logic signed [19:0] clamp_val;
   logic [31:0] age;
   logic signed [19:0] tgt_x, tgt_y, diff_x, diff_y, stp;

   assign cur_avg  = axis_ff ? avg_y_ff : avg_x_ff;
   assign cur_raw  = axis_ff ? raw_y_ff : raw_x_ff;
   assign cur_tilt = axis_ff ? tilt_y_ff : tilt_x_ff;
   assign lim_s    = {6'd0, tilt_limit_ff};
   assign rnd16    = acc_ff + 50'sd32768;
   assign pd_val   = rnd16[49:16];
   assign clamp_val = (pd_val > 34'(lim_s)) ? lim_s :
                      (pd_val < -34'(lim_s)) ? -lim_s : 20'(pd_val);
   assign age      = now_ff - ring_rd_ff[31:0];
   assign tgt_x    = 20'(signed'(ring_rd_ff[50:32]));
   assign tgt_y    = 20'(signed'(ring_rd_ff[69:51]));
   // The largest step stays below 2^19, so the cap only guards the width.
   assign stp      = 20'(step_ff > 30'd524287 ? 30'd524287 : step_ff);
   assign diff_x   = 20'(cmd_x_ff) - 20'(slew_x_ff);
   assign diff_y   = 20'(cmd_y_ff) - 20'(slew_y_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_AVG_A: begin
            mul_a = 33'({1'b0, rate_alpha_ff});
            mul_b = 33'(cur_raw);
         end
         ST_AVG_B: begin
            mul_a = 33'(17'd65536 - 17'({1'b0, rate_alpha_ff}));
            mul_b = 33'(cur_avg);
         end
         ST_PD_A: begin
            mul_a = 33'({1'b0, prop_gain_ff});
            mul_b = 33'(cur_tilt);
         end
         ST_PD_B: begin
            // The average of this axis was updated at the end of ST_AVG_B.
            mul_a = 33'({1'b0, deriv_gain_ff});
            mul_b = 33'(cur_avg);
         end
         ST_SCALE: begin
            mul_a = 33'(clamp_val);
            mul_b = 33'({1'b0, axis_ff ? scale_y_ff : scale_x_ff});
         end
         ST_STEP: begin
            mul_a = 33'({1'b0, slew_dps_ff});
            mul_b = 33'({1'b0, dt_ff});
         end
         ST_DIV: begin
            mul_a = 33'({1'b0, prod_ff[30:0], 8'd0}) ;
            mul_b = 33'({1'b0, RECIP_1000});
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_tvalid) state_in = ST_AVG_A;
         ST_AVG_A:     state_in = ST_AVG_B;
         ST_AVG_B:     state_in = ST_PD_A;
         ST_PD_A:      state_in = ST_PD_B;
         ST_PD_B:      state_in = ST_SCALE;
         ST_SCALE:     state_in = ST_AXIS_NEXT;
         ST_AXIS_NEXT: state_in = axis_ff ? (delay_ms_ff != '0 ? ST_RING_WR : ST_STEP)
                                         : ST_AVG_A;
         ST_RING_WR:   state_in = ST_RING_RD;
         ST_RING_RD:   state_in = ST_RING_CHK;
         ST_RING_CHK:  state_in = (age < 32'(delay_ms_ff)) ? ST_DONE : ST_STEP;
         ST_STEP:      state_in = ST_DIV;
         ST_DIV:       state_in = ST_SLEW;
         ST_SLEW:      state_in = ST_DONE;
         ST_DONE:      if (!out_valid_ff) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   logic signed [49:0] scaled;
   assign scaled = 50'(prod_ff) + 50'sd128;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         avg_x_ff     <= '0;
         avg_y_ff     <= '0;
         slew_x_ff    <= '0;
         slew_y_ff    <= '0;
         last_time_ff <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_valid_ff && rsp_tready) out_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: if (req_tvalid) begin
               if (req_tuser) begin
                  avg_x_ff <= '0; avg_y_ff <= '0;
                  slew_x_ff <= '0; slew_y_ff <= '0;
                  head_ff <= '0; count_ff <= '0;
                  last_time_ff <= req_tdata[31:0];
               end
            end
            ST_AVG_B: begin
               if (axis_ff) avg_y_ff <= 20'((acc_ff + 50'(mul_p) + 50'sd32768) >>> 16);
               else         avg_x_ff <= 20'((acc_ff + 50'(mul_p) + 50'sd32768) >>> 16);
            end
            ST_RING_WR: begin
               head_ff <= (head_ff == PW'(RING_DEPTH - 1)) ? '0 : head_ff + 1'b1;
               if (count_ff != CW'(RING_DEPTH)) count_ff <= count_ff + 1'b1;
            end
            ST_RING_CHK: if (age >= 32'(delay_ms_ff)) count_ff <= count_ff - 1'b1;
            ST_SLEW: begin
               last_time_ff <= now_ff;
               if (slew_dps_ff == '0) begin
                  slew_x_ff <= cmd_x_ff; slew_y_ff <= cmd_y_ff;
               end else begin
                  slew_x_ff <= 19'(20'(slew_x_ff) + ((diff_x > stp) ? stp :
                               (diff_x < -stp) ? -stp : diff_x));
                  slew_y_ff <= 19'(20'(slew_y_ff) + ((diff_y > stp) ? stp :
                               (diff_y < -stp) ? -stp : diff_y));
               end
            end
            ST_DONE: if (!out_valid_ff) out_valid_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   // Tail index with wrap for depths that are not a power of two.
   logic [PW:0] tail_wide;
   always_comb begin
      tail_wide = {1'b0, head_ff} + (PW+1)'(RING_DEPTH) - (PW+1)'(count_ff);
      if (tail_wide >= (PW+1)'(RING_DEPTH)) tail_wide = tail_wide - (PW+1)'(RING_DEPTH);
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: if (req_tvalid) begin
            now_ff     <= req_tdata[31:0];
            tilt_x_ff  <= req_tdata[48:32];
            tilt_y_ff  <= req_tdata[65:49];
            raw_x_ff   <= req_tdata[85:66];
            raw_y_ff   <= req_tdata[105:86];
            axis_ff    <= 1'b0;
            sat_ff     <= 1'b0;
            valid_ff   <= 1'b1;
         end
         ST_AVG_A: acc_ff <= 50'(mul_p);
         ST_AVG_B: ;
         ST_PD_A:  acc_ff <= 50'(mul_p);
         ST_PD_B:  acc_ff <= acc_ff + 50'(mul_p);
         ST_SCALE: begin
            if (pd_val > 34'(lim_s) || pd_val < -34'(lim_s)) sat_ff <= 1'b1;
            prod_ff <= 64'(mul_p);
         end
         ST_AXIS_NEXT: begin
            if (axis_ff) cmd_y_ff <= 19'(scaled >>> 8);
            else         cmd_x_ff <= 19'(scaled >>> 8);
            axis_ff <= ~axis_ff;
            dt_ff   <= now_ff - last_time_ff;
         end
         ST_RING_WR: ring_mem[head_ff] <= {cmd_y_ff, cmd_x_ff, now_ff};
         ST_RING_RD: ring_rd_ff <= ring_mem[tail_wide[PW-1:0]];
         ST_RING_CHK: begin
            if (age < 32'(delay_ms_ff)) valid_ff <= 1'b0;
            cmd_x_ff <= tgt_x[18:0];
            cmd_y_ff <= tgt_y[18:0];
         end
         ST_STEP: begin
            if (dt_ff == '0 || dt_ff > 32'd500) prod_ff <= 64'(slew_dps_ff) * 64'd10;
            else prod_ff <= 64'(mul_p);
         end
         ST_DIV:  step_ff <= 30'(mul_p >>> 40);
         ST_DONE: if (!out_valid_ff) begin
            out_user_ff <= valid_ff;
            out_data_ff <= {1'b0, sat_ff,
                            valid_ff ? 19'(slew_y_ff) : 19'd0,
                            valid_ff ? 19'(slew_x_ff) : 19'd0};
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   `PDC_ASSERT(a_busy_not_ready, clock, reset,
      (state_ff != ST_IDLE) |-> !req_tready, "ready while busy")
   `PDC_ASSERT(a_count_bound, clock, reset,
      1'b1 |-> (count_ff <= CW'(RING_DEPTH)), "ring count above depth")
   `PDC_ASSERT(a_hold_rsp, clock, reset,
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)),
      "result changed while stalled")
   `PDC_ASSERT(a_reset_idle, clock, reset,
      $past(reset) |-> (state_ff == ST_IDLE), "not idle after reset")
   `PDC_ASSERT_ALWAYS(a_pready_high, clock,
      csr_pready, "pready low")
endmodule

### tb/pd_actuator_delay_slew_chain_top_test.sv
// -----------------------------------------------------------------------------
// pd_actuator_delay_slew_chain_top_test
// Self-checking bench for the two-axis PD, delay ring and slew chain.
// A predictor in the bench follows every accepted tick. It works out the
// command that the block should return, and the monitor compares each
// returned item with it field by field. The run walks through several
// register settings and handshake idling phases.
// -----------------------------------------------------------------------------
module pd_actuator_delay_slew_chain_top_test;
   import pdc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = RING_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 1000000;

   // One control tick as the bench sees it.
   typedef struct packed {
      logic               restart;
      logic        [31:0] now_ms;
      logic signed [16:0] tilt_x;
      logic signed [16:0] tilt_y;
      logic signed [19:0] raw_rate_x;
      logic signed [19:0] raw_rate_y;
   } tick_type;

   // One command as the block returns it.
   typedef struct packed {
      logic               cmd_valid;
      logic signed [18:0] servo_x;
      logic signed [18:0] servo_y;
      logic               saturated;
   } command_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [111:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   pd_actuator_delay_slew_chain_top i_dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Predictor state: a copy of the registers and of the block's memory.
   longint gain_p, gain_d, lim_tilt, mult_x, mult_y, hold_ms, slew_rate, alpha;
   longint smooth_x, smooth_y, slewed_x, slewed_y;
   logic [31:0] last_release_ms;
   longint delay_cmd_x [DEPTH];
   longint delay_cmd_y [DEPTH];
   logic [31:0] delay_stamp [DEPTH];
   int     wr_ptr, fill;

   tick_type     pending_ticks[$];
   command_type  expected_cmds[$];
   int        error_count = 0;
   int        cmds_seen = 0;
   int        released_seen = 0;
   longint    cycle_count = 0;
   int        send_idle_pct = 0;
   int        recv_stall_pct = 0;

   // Round half up by n bits; an arithmetic shift floors for both signs.
   function automatic longint round_shift(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint clamp_sym(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   task automatic reset_predictor();
      gain_p = PROP_GAIN_RST; gain_d = DERIV_GAIN_RST; lim_tilt = TILT_LIMIT_RST;
      mult_x = SCALE_X_RST; mult_y = SCALE_Y_RST; hold_ms = 0; slew_rate = 0;
      alpha = RATE_ALPHA_RST;
      smooth_x = 0; smooth_y = 0; slewed_x = 0; slewed_y = 0;
      last_release_ms = '0; wr_ptr = 0; fill = 0;
   endtask

   // Work out the command that one tick should produce and advance the state.
   function automatic command_type predict_command(tick_type t);
      command_type c;
      longint pd_x, pd_y, tgt_x, tgt_y, step;
      logic [31:0] dt;
      logic [31:0] age;
      int tail;
      logic released;
      released = 1'b1;
      if (t.restart) begin
         smooth_x = 0; smooth_y = 0; slewed_x = 0; slewed_y = 0;
         wr_ptr = 0; fill = 0;
         last_release_ms = t.now_ms;
      end
      smooth_x = round_shift(alpha * t.raw_rate_x + (65536 - alpha) * smooth_x, 16);
      smooth_y = round_shift(alpha * t.raw_rate_y + (65536 - alpha) * smooth_y, 16);
      pd_x = round_shift(gain_p * t.tilt_x + gain_d * smooth_x, 16);
      pd_y = round_shift(gain_p * t.tilt_y + gain_d * smooth_y, 16);
      c.saturated = (pd_x > lim_tilt) || (pd_x < -lim_tilt) ||
                    (pd_y > lim_tilt) || (pd_y < -lim_tilt);
      tgt_x = round_shift(clamp_sym(pd_x, lim_tilt) * mult_x, 8);
      tgt_y = round_shift(clamp_sym(pd_y, lim_tilt) * mult_y, 8);
      if (hold_ms != 0) begin
         delay_cmd_x[wr_ptr] = tgt_x;
         delay_cmd_y[wr_ptr] = tgt_y;
         delay_stamp[wr_ptr] = t.now_ms;
         wr_ptr = (wr_ptr + 1) % DEPTH;
         if (fill < DEPTH) fill++;
         tail = (wr_ptr + DEPTH - fill) % DEPTH;
         // The age wraps modulo 2^32 like the timestamps.
         age = t.now_ms - delay_stamp[tail];
         if (age < hold_ms) begin
            released = 1'b0;
         end else begin
            tgt_x = delay_cmd_x[tail];
            tgt_y = delay_cmd_y[tail];
            fill--;
         end
      end
      if (released) begin
         dt = t.now_ms - last_release_ms;
         last_release_ms = t.now_ms;
         if (dt == 0 || dt > 500) dt = 10;
         step = (slew_rate * 256 * longint'(dt)) / 1000;
         if (slew_rate == 0) begin
            slewed_x = tgt_x; slewed_y = tgt_y;
         end else begin
            slewed_x = slewed_x + clamp_sym(tgt_x - slewed_x, step);
            slewed_y = slewed_y + clamp_sym(tgt_y - slewed_y, step);
         end
      end
      c.cmd_valid = released;
      c.servo_x = released ? 19'(slewed_x) : '0;
      c.servo_y = released ? 19'(slewed_y) : '0;
      return c;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH item %0d %s: got %0d expected %0d", cmds_seen, what, got, want);
      error_count++;
   endtask

   // Driver: presents queued ticks and predicts each one as it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_cmds.push_back(predict_command(pending_ticks.pop_front()));
         end
         if ((!req_tvalid || req_tready) ) begin
            // The head may have just been popped above, so look again.
            if (pending_ticks.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tuser  <= pending_ticks[0].restart;
               req_tdata  <= {6'b0, pending_ticks[0].raw_rate_y, pending_ticks[0].raw_rate_x,
                              pending_ticks[0].tilt_y, pending_ticks[0].tilt_x,
                              pending_ticks[0].now_ms};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks every returned item against the oldest prediction.
   always @(posedge clock) begin
      command_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            cmds_seen++;
            if (expected_cmds.size() == 0) begin
               report_mismatch("unexpected item", 0, 0);
            end else begin
               want = expected_cmds.pop_front();
               if (rsp_tuser !== want.cmd_valid)
                  report_mismatch("cmd_valid", rsp_tuser, want.cmd_valid);
               if (rsp_tdata[18:0] !== want.servo_x)
                  report_mismatch("servo_x", $signed(rsp_tdata[18:0]), want.servo_x);
               if (rsp_tdata[37:19] !== want.servo_y)
                  report_mismatch("servo_y", $signed(rsp_tdata[37:19]), want.servo_y);
               if (rsp_tdata[38] !== want.saturated)
                  report_mismatch("saturated", rsp_tdata[38], want.saturated);
               if (want.cmd_valid) released_seen++;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles.", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Register write: setup cycle, then access cycle.
   task automatic write_reg(logic [2:0] index, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= {index, 2'b00}; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (index)
         REG_PROP_GAIN:  gain_p    = value[15:0];
         REG_DERIV_GAIN: gain_d    = value[15:0];
         REG_TILT_LIMIT: lim_tilt  = value[13:0];
         REG_SCALE_X:    mult_x    = value[11:0];
         REG_SCALE_Y:    mult_y    = value[11:0];
         REG_DELAY_MS:   hold_ms   = value[9:0];
         REG_SLEW_DPS:   slew_rate = value[11:0];
         REG_RATE_ALPHA: alpha     = value[15:0];
         default: ;
      endcase
   endtask

   // Wait until all queued ticks are in and all their commands are out.
   task automatic drain();
      while (pending_ticks.size() > 0 || expected_cmds.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   logic [31:0] clock_ms = 32'd1000;

   task automatic queue_tick(logic restart, logic [31:0] now, longint tx, longint ty,
                             longint rx, longint ry);
      tick_type t;
      t.restart = restart; t.now_ms = now;
      t.tilt_x = tx; t.tilt_y = ty; t.raw_rate_x = rx; t.raw_rate_y = ry;
      pending_ticks.push_back(t);
   endtask

   // Random tick: time mostly moves 1..40 ms, sometimes jumps, stays or wraps.
   task automatic queue_random_tick();
      int pick;
      pick = $urandom_range(99);
      if (pick < 5) clock_ms = $urandom;
      else if (pick < 10) clock_ms = clock_ms + $urandom_range(501, 3000);
      else if (pick < 15) ;
      else clock_ms = clock_ms + $urandom_range(1, 40);
      queue_tick($urandom_range(99) < 3, clock_ms,
                 $urandom_range(92160) - 46080, $urandom_range(92160) - 46080,
                 longint'($signed(20'($urandom))), longint'($signed(20'($urandom))));
   endtask

   initial begin
      logic [31:0] settings [6][8];
      int phase;
      reset_predictor();
      // Each row: prop, deriv, limit, scale_x, scale_y, delay, slew, alpha.
      settings[0] = '{5243, 5243, 1280, 2081, 1108, 0, 0, 58982};
      settings[1] = '{65535, 65535, 11520, 4095, 4095, 0, 4000, 65535};
      settings[2] = '{0, 0, 0, 0, 0, 1000, 1, 0};
      settings[3] = '{30000, 12000, 6000, 900, 3000, 25, 300, 40000};
      settings[4] = '{65535, 0, 16383, 4095, 1, 3, 0, 1};
      settings[5] = '{1000, 65535, 100, 256, 256, 120, 4095, 32768};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed ticks at the default settings: field extremes, restart, time
      // that stands still, wraps or jumps beyond half a second.
      queue_tick(1, 32'd0, 46080, -46080, 524287, -524288);
      queue_tick(0, 32'd0, -46080, 46080, -524288, 524287);
      queue_tick(0, 32'd700, 0, 0, 0, 0);
      queue_tick(0, 32'hFFFF_FFFF, -65536, 65535, -1, 1);
      queue_tick(0, 32'd3, 65535, -65536, 262144, -262144);
      queue_tick(1, 32'h8000_0000, 100, -100, 1000, -1000);
      queue_tick(0, 32'h8000_0005, 46080, 46080, 524287, 524287);
      drain();
      // Delay with a full ring: a long hold overwrites the oldest entries.
      write_reg(REG_DELAY_MS, 1000);
      write_reg(REG_SLEW_DPS, 4000);
      for (int k = 0; k < 70; k++)
         queue_tick(k == 0, 32'd5000 + 32'(k), 20000 - 600 * k, 300 * k, 5000, -5000);
      queue_tick(0, 32'd9000, 46080, -46080, 0, 0);
      drain();

      // Random phases across settings and idling.
      for (phase = 0; phase < 12; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
         endcase
         for (int r = 0; r < 8; r++)
            write_reg(3'(r), (phase < 6) ? settings[phase][r] : $urandom);
         for (int k = 0; k < 125; k++) queue_random_tick();
         drain();
      end

      $display("Covered %0d commands, %0d released, over six fixed and six random settings.",
               cmds_seen, released_seen);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches.", error_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

### files.f
+incdir+design
design/pdc_pkg.sv
design/pd_actuator_delay_slew_chain_top.sv
tb/pd_actuator_delay_slew_chain_top_test.sv
